// ===== sv/linear_probe_hash_table_top_assert.svh =====
// assertion macros shared by the hash table modules
// no dependencies; pulled in by the files that check their own logic
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LPHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lpht_pkg.sv =====
// shared types, codes and constants of the linear probe hash table
// no dependencies; imported by every module of the block
package lpht_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIFO_DEPTH     = 2;

    // fnv-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_value;
        logic [7:0]  slot_index;
    } t_result;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DONE
    } t_back_state;

    // width of one classified job: mode, key, length, value, home slot
    function automatic int job_width(input int capacity, input int key_bytes,
                                     input int value_bits);
        return 1 + 8 * key_bytes + 4 + value_bits + $clog2(capacity);
    endfunction

endpackage

// ===== sv/lpht_fifo.sv =====
// small first-in first-out queue with push/full and pop/empty handshakes
// depends on lpht_pkg and the assertion macro header
module lpht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lpht_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import lpht_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    // handshake status
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`include "linear_probe_hash_table_top_assert.svh"

    `LPHT_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "fifo overfilled")
    `LPHT_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "fifo count lost a push")
    `LPHT_ASSERT_IMPL(a_empty_ptrs, i_clk, i_rst_n, o_empty, r_wr_ptr == r_rd_ptr, "fifo pointers apart while empty")

endmodule

// ===== sv/lpht_front.sv =====
// front end: takes input beats, trims the key and hashes it byte by byte
// depends on lpht_pkg; feeds the job queue
module lpht_front #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hold,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_mode,
    input  logic [63:0] i_key_bytes_packed,
    input  logic [3:0]  i_key_length,
    input  logic [31:0] i_insert_value,
    output logic        o_job_push,
    output logic [lpht_pkg::job_width(CAPACITY, KEY_BYTES, VALUE_BITS)-1:0] o_job,
    input  logic        i_job_full
);
    import lpht_pkg::*;

    localparam int KEY_BITS = 8 * KEY_BYTES;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] CAP_MASK = IDX_W'(CAPACITY - 1);

    typedef struct packed {
        logic                  mode;
        logic [KEY_BITS-1:0]   key;
        logic [3:0]            len;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      home;
    } t_job;

    t_front_state        r_state, n_state;
    t_job                r_job, n_job;
    t_job                job_out;
    logic [31:0]         r_hash, n_hash;
    logic [KEY_BITS-1:0] r_shift, n_shift;
    logic [3:0]          r_left, n_left;
    logic [3:0]          len_c;
    logic [KEY_BITS-1:0] key_m;

    assign o_job = job_out;

    // clamp length and clear bytes beyond it
    always_comb begin
        len_c = (i_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_length;
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_m[b*8 +: 8] = (4'(b) < len_c) ? i_key_bytes_packed[b*8 +: 8] : 8'h00;
        end
    end

    // next state, one hash byte per cycle
    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_hash     = r_hash;
        n_shift    = r_shift;
        n_left     = r_left;
        o_full     = (r_state != F_IDLE) || i_hold;
        o_job_push = 1'b0;
        job_out    = r_job;
        unique case (r_state)
            F_IDLE: begin
                if (i_push && !o_full) begin
                    n_job.mode  = i_mode;
                    n_job.key   = key_m;
                    n_job.len   = len_c;
                    n_job.value = VALUE_BITS'(i_insert_value);
                    n_job.home  = '0;
                    n_hash      = FNV_BASIS;
                    n_shift     = key_m;
                    n_left      = len_c;
                    n_state     = (len_c == 4'd0) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                n_hash  = 32'((r_hash ^ {24'h0, r_shift[7:0]}) * FNV_PRIME);
                n_shift = r_shift >> 8;
                n_left  = r_left - 1'b1;
                if (r_left == 4'd1) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                // masked hash is already below capacity, so no fold is needed
                job_out.home = r_hash[IDX_W-1:0] & CAP_MASK;
                o_job_push   = !i_job_full;
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_hash  <= n_hash;
        r_shift <= n_shift;
        r_left  <= n_left;
    end

endmodule

// ===== sv/lpht_back.sv =====
// back end: clears the slot memory after reset, then probes it linearly
// depends on lpht_pkg and the assertion macro header; owns the slot memory
module lpht_back #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_clearing,
    input  logic [lpht_pkg::job_width(CAPACITY, KEY_BYTES, VALUE_BITS)-1:0] i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    output logic              o_res_push,
    output lpht_pkg::t_result o_res,
    input  logic              i_res_full
);
    import lpht_pkg::*;

    localparam int KEY_BITS = 8 * KEY_BYTES;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

    typedef struct packed {
        logic                  mode;
        logic [KEY_BITS-1:0]   key;
        logic [3:0]            len;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      home;
    } t_job;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [3:0]            len;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    t_slot            r_mem [CAPACITY];
    t_slot            r_rd_data;
    t_slot            mem_wdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;

    t_back_state      r_state, n_state;
    logic [IDX_W-1:0] r_clr_addr, n_clr_addr;
    t_job             r_job, n_job;
    t_job             job_in;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_visits, n_visits;
    t_result          r_res, n_res;
    logic             hit;

    assign job_in     = i_job;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_res      = r_res;
    assign hit        = (r_rd_data.key == r_job.key) && (r_rd_data.len == r_job.len);

    // clear sweep, then one probe per cycle against the registered read
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_job      = r_job;
        n_idx      = r_idx;
        n_visits   = r_visits;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '0;
        mem_raddr  = r_idx;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = job_in;
                    n_idx     = job_in.home;
                    n_visits  = '0;
                    mem_raddr = job_in.home;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res = '{status: ST_MISSING, found_value: '0, slot_index: '0};
                if (!r_rd_data.valid) begin
                    // empty slot ends the probe
                    if (r_job.mode == MODE_INSERT) begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.key   = r_job.key;
                        mem_wdata.len   = r_job.len;
                        mem_wdata.value = r_job.value;
                        n_res.status     = ST_INSERTED;
                        n_res.slot_index = 8'(r_idx);
                    end
                    n_state = S_DONE;
                end else if (hit) begin
                    if (r_job.mode == MODE_INSERT) begin
                        n_res.status = ST_PRESENT;
                    end else begin
                        n_res.status      = ST_FOUND;
                        n_res.found_value = 32'(r_rd_data.value);
                    end
                    n_res.slot_index = 8'(r_idx);
                    n_state = S_DONE;
                end else if (r_visits == LAST) begin
                    // every slot visited
                    if (r_job.mode == MODE_INSERT) begin
                        n_res.status = ST_FULL;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx     = (r_idx == LAST) ? '0 : r_idx + 1'b1;
                    n_visits  = r_visits + 1'b1;
                    mem_raddr = n_idx;
                end
            end
            S_DONE: begin
                o_res_push = !i_res_full;
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_idx    <= n_idx;
        r_visits <= n_visits;
        r_res    <= n_res;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

`include "linear_probe_hash_table_top_assert.svh"

    `LPHT_ASSERT_IMPL(a_no_pop_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_job_pop, "job taken during clear sweep")
    `LPHT_ASSERT_IMPL(a_we_state, i_clk, i_rst_n, mem_we, r_state == S_CLEAR || r_state == S_CHECK, "slot write outside sweep or probe")
    `LPHT_ASSERT_NEXT(a_pop_probe, i_clk, i_rst_n, o_job_pop, r_state == S_CHECK, "job popped without probing")
    `LPHT_ASSERT_IMPL(a_res_push, i_clk, i_rst_n, o_res_push, r_state == S_DONE && !i_res_full, "result pushed out of turn")

endmodule

// ===== sv/linear_probe_hash_table_top.sv =====
// Exact-match key/value table with open addressing and linear probing.
// Input channel: push/full; a beat carries mode (insert or lookup), up to
// KEY_BYTES key bytes with a length, and a value word. Result channel:
// empty/pop; a beat carries status, found value and slot index, one per input.
// Flow: the front hashes key_length bytes (0..KEY_BYTES) byte by byte and
// queues the job; the back fetches the home slot, probes one slot per cycle
// (1..CAPACITY slots) and posts the result.
// The front takes a new beat only once the last one is hashed and queued,
// limited by the byte-serial hash multiplier; the back overlaps with it
// through a two-entry job queue and takes one item at a time, set by the
// one read port of the slot memory.
// Reset: all CAPACITY slots are marked empty by a sweep; full stays high
// during the sweep.
// A stalled receiver fills the two-entry result queue, then the back end
// waits, then the job queue and finally full rises; nothing is dropped.
// depends on lpht_pkg, lpht_front, lpht_fifo, lpht_back
module linear_probe_hash_table_top #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [63:0] i_key_bytes_packed,
    input  logic [3:0]  i_key_length,
    input  logic [31:0] i_insert_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_value,
    output logic [7:0]  o_slot_index
);
    import lpht_pkg::*;

    localparam int JOB_W = job_width(CAPACITY, KEY_BYTES, VALUE_BITS);
    localparam int RES_W = $bits(t_result);

    logic             clearing;
    logic             job_push, job_full, job_pop, job_empty;
    logic [JOB_W-1:0] job_in, job_out;
    logic             res_push, res_full;
    t_result          res_in, res_out;
    logic [RES_W-1:0] res_out_bits;

    // classify and hash
    lpht_front #(
        .CAPACITY   (CAPACITY),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_hold             (clearing),
        .i_push             (push),
        .o_full             (full),
        .i_mode             (i_mode),
        .i_key_bytes_packed (i_key_bytes_packed),
        .i_key_length       (i_key_length),
        .i_insert_value     (i_insert_value),
        .o_job_push         (job_push),
        .o_job              (job_in),
        .i_job_full         (job_full)
    );

    // job queue between front and back
    lpht_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (FIFO_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // probe engine and slot memory
    lpht_back #(
        .CAPACITY   (CAPACITY),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // result queue toward the receiver
    lpht_fifo #(
        .WIDTH (RES_W),
        .DEPTH (FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out_bits),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_out_bits);
    assign o_status      = res_out.status;
    assign o_found_value = res_out.found_value;
    assign o_slot_index  = res_out.slot_index;

endmodule

// ===== tb/tb_linear_probe_hash_table_top.sv =====
`timescale 1ns / 100ps
// testbench for linear_probe_hash_table_top: directed and random insert/lookup beats
// checked against a behavioral shadow of the slot table; depends on lpht_pkg and the rtl
module tb_linear_probe_hash_table_top;
    import lpht_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int KEY_BYTES    = KEY_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1380;
    localparam int FILL_CAP     = 224;
    localparam int DRAIN_CYCLES = CAPACITY + 2 * KEY_BYTES + 16;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  len;
    } t_stored_key;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_mode;
    logic [63:0] i_key_bytes_packed;
    logic [3:0]  i_key_length;
    logic [31:0] i_insert_value;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic [31:0] o_found_value;
    logic [7:0]  o_slot_index;

    // shadow copy of the slot table
    logic        shadow_used  [CAPACITY];
    logic [63:0] shadow_key   [CAPACITY];
    logic [3:0]  shadow_len   [CAPACITY];
    logic [31:0] shadow_value [CAPACITY];
    int unsigned entry_count;

    t_result     expected_results [$];
    t_stored_key stored_keys [$];

    int mismatch_count;
    int result_count;
    int cycle_count;
    int tx_steady;
    int rx_steady;
    int pop_hold;

    linear_probe_hash_table_top #(
        .CAPACITY   (CAPACITY),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_mode             (i_mode),
        .i_key_bytes_packed (i_key_bytes_packed),
        .i_key_length       (i_key_length),
        .i_insert_value     (i_insert_value),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_found_value      (o_found_value),
        .o_slot_index       (o_slot_index)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mask of the bytes that belong to a key of the given length
    function automatic logic [63:0] key_mask(input int unsigned len);
        if (len >= 8)
            return {64{1'b1}};
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    // 32-bit fnv-1a over the key bytes, byte 0 first
    function automatic logic [31:0] fnv1a_hash(input logic [63:0] key, input int unsigned len);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < len && i < 8; i++) begin
            h = h ^ {24'd0, key[8 * i +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // random key bytes, sometimes with zero bytes mixed in
    function automatic logic [63:0] random_key();
        logic [63:0] k;
        k = {$urandom(), $urandom()};
        if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < 8; i++)
                if ($urandom_range(0, 1) == 1)
                    k[8 * i +: 8] = 8'h00;
        end
        return k;
    endfunction

    // idle length: mostly none or short, a few long, with runs of no idling
    task automatic draw_gap(inout int steady, output int gap);
        int r;
        r = $urandom_range(0, 99);
        if (steady > 0) begin
            steady--;
            gap = 0;
        end else if (r < 3) begin
            steady = $urandom_range(20, 80);
            gap = 0;
        end else if (r < 55) begin
            gap = 0;
        end else if (r < 88) begin
            gap = $urandom_range(1, 3);
        end else if (r < 98) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 60);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch on result %0d: %s", $time, result_count, what);
    endtask

    // walk the shadow table for one accepted beat and queue its result
    task automatic predict_access(input t_mode mode, input logic [63:0] key_in,
                                  input logic [3:0] len_in, input logic [31:0] value);
        int unsigned len;
        int unsigned idx;
        logic [63:0] key;
        bit          done;
        t_result     res;
        len = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
        key = key_in & key_mask(len);
        idx = (fnv1a_hash(key, len) & (CAPACITY - 1)) % CAPACITY;
        res.status      = (mode == MODE_INSERT) ? ST_FULL : ST_MISSING;
        res.found_value = '0;
        res.slot_index  = '0;
        done = 1'b0;
        for (int n = 0; n < CAPACITY && !done; n++) begin
            if (!shadow_used[idx]) begin
                if (mode == MODE_INSERT) begin
                    shadow_used[idx]  = 1'b1;
                    shadow_key[idx]   = key;
                    shadow_len[idx]   = len[3:0];
                    shadow_value[idx] = value;
                    entry_count++;
                    res.status     = ST_INSERTED;
                    res.slot_index = idx[7:0];
                    stored_keys.push_back('{key: key, len: len[3:0]});
                end
                done = 1'b1;
            end else if (shadow_key[idx] == key && shadow_len[idx] == len[3:0]) begin
                if (mode == MODE_INSERT) begin
                    res.status = ST_PRESENT;
                end else begin
                    res.status      = ST_FOUND;
                    res.found_value = shadow_value[idx];
                end
                res.slot_index = idx[7:0];
                done = 1'b1;
            end else begin
                idx = (idx + 1) % CAPACITY;
            end
        end
        expected_results.push_back(res);
    endtask

    // drive one input beat after a random gap and wait for it to be taken
    task automatic send_beat(input t_mode mode, input logic [63:0] key,
                             input logic [3:0] len, input logic [31:0] value);
        int gap;
        draw_gap(tx_steady, gap);
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push               <= 1'b1;
        i_mode             <= mode;
        i_key_bytes_packed <= key;
        i_key_length       <= len;
        i_insert_value     <= value;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        predict_access(mode, key, len, value);
    endtask

    task automatic test_empty_table();
        send_beat(MODE_LOOKUP, 64'h0, 4'd0, 32'h0);
        send_beat(MODE_LOOKUP, {64{1'b1}}, 4'd8, {32{1'b1}});
        send_beat(MODE_LOOKUP, 64'h0, 4'd15, 32'h0);
    endtask

    task automatic test_key_edge_cases();
        // empty key, garbage above the length
        send_beat(MODE_INSERT, 64'hDEAD_BEEF_0000_0000, 4'd0, 32'hFFFF_FFFF);
        send_beat(MODE_INSERT, 64'h1234_5678_9ABC_DEF0, 4'd0, 32'h0);
        send_beat(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0);
        // all-ones key, overlong length folds to full length
        send_beat(MODE_INSERT, {64{1'b1}}, 4'd8, 32'h0);
        send_beat(MODE_LOOKUP, {64{1'b1}}, 4'd15, 32'hFFFF_FFFF);
        send_beat(MODE_INSERT, {64{1'b1}}, 4'd12, 32'h1);
        // zero bytes inside the length are real key bytes
        send_beat(MODE_INSERT, 64'h0, 4'd8, 32'h5A5A_A5A5);
        send_beat(MODE_INSERT, 64'h0, 4'd1, 32'h0000_0001);
        send_beat(MODE_LOOKUP, 64'h0, 4'd2, 32'h0);
        send_beat(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, 32'h0);
        send_beat(MODE_LOOKUP, 64'h0, 4'd7, 32'h0);
        send_beat(MODE_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_beat(MODE_INSERT, 64'h0102_0304_0506_0708, 4'd8, 32'h8000_0000);
        send_beat(MODE_LOOKUP, 64'h0102_0304_0506_0708, 4'd8, 32'h0);
    endtask

    task automatic test_probe_wraparound();
        logic [63:0] wrap_keys [$];
        // two-byte keys whose home is the last slot
        for (int b = 0; b < 65536 && wrap_keys.size() < 4; b++)
            if ((fnv1a_hash(64'(b), 2) & (CAPACITY - 1)) == CAPACITY - 1)
                wrap_keys.push_back(64'(b));
        for (int i = 0; i < 3; i++)
            send_beat(MODE_INSERT, wrap_keys[i], 4'd2, $urandom());
        send_beat(MODE_LOOKUP, wrap_keys[2], 4'd2, 32'h0);
        send_beat(MODE_LOOKUP, wrap_keys[3], 4'd2, 32'h0);
        send_beat(MODE_INSERT, wrap_keys[3], 4'd2, $urandom());
    endtask

    task automatic test_random_traffic(input int n_items);
        t_stored_key pick;
        logic [63:0] key;
        int unsigned len;
        t_mode       mode;
        int          r;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            mode = t_mode'($urandom_range(0, 1));
            if (stored_keys.size() != 0 && r < 50) begin
                // stored key with fresh garbage above its length
                pick = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                key = pick.key | (random_key() & ~key_mask(pick.len));
                len = pick.len;
                if (len == KEY_BYTES && $urandom_range(0, 3) == 0)
                    len = $urandom_range(KEY_BYTES, 15);
                // near miss: length off by one or one bit flipped
                if (r >= 40) begin
                    if (pick.len == 0 || $urandom_range(0, 1) == 1)
                        len = (pick.len == 0) ? 1 : pick.len - 1;
                    else
                        key = key ^ (64'd1 << $urandom_range(0, 8 * pick.len - 1));
                end
            end else begin
                key = random_key();
                if (r < 75)
                    len = $urandom_range(0, 2);
                else if (r < 95)
                    len = $urandom_range(3, 8);
                else
                    len = $urandom_range(9, 15);
            end
            // keep room in the table until the fill test
            if (r >= 40 && mode == MODE_INSERT && entry_count >= FILL_CAP)
                mode = MODE_LOOKUP;
            send_beat(mode, key, len[3:0], $urandom());
        end
    endtask

    task automatic test_table_full();
        t_stored_key pick;
        // top up with fresh full-length keys
        while (entry_count < CAPACITY)
            send_beat(MODE_INSERT, random_key(), 4'(KEY_BYTES), $urandom());
        // new keys are refused
        repeat (8)
            send_beat(MODE_INSERT, random_key(), 4'(KEY_BYTES), $urandom());
        // duplicates still report their slot, stored keys still found
        repeat (8) begin
            pick = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            send_beat(t_mode'($urandom_range(0, 1)), pick.key, pick.len, $urandom());
        end
        // misses walk every slot
        repeat (6)
            send_beat(MODE_LOOKUP, random_key(), 4'($urandom_range(3, 15)), $urandom());
    endtask

    // result side pacing
    initial begin
        forever begin
            @(negedge i_clk);
            if (pop_hold > 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else if ($urandom_range(0, 9) == 0) begin
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result exp_res;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, status %0d", o_status));
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_status, exp_res.status));
                if (o_found_value !== exp_res.found_value)
                    report_mismatch($sformatf("found_value %h, want %h",
                                              o_found_value, exp_res.found_value));
                if (o_slot_index !== exp_res.slot_index)
                    report_mismatch($sformatf("slot_index %0d, want %0d",
                                              o_slot_index, exp_res.slot_index));
            end
            result_count++;
            draw_gap(rx_steady, pop_hold);
        end
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : run_tests
        i_rst_n            = 1'b0;
        push               = 1'b0;
        pop                = 1'b0;
        i_mode             = MODE_INSERT;
        i_key_bytes_packed = '0;
        i_key_length       = '0;
        i_insert_value     = '0;
        entry_count        = 0;
        mismatch_count     = 0;
        result_count       = 0;
        tx_steady          = 0;
        rx_steady          = 0;
        pop_hold           = 0;
        for (int s = 0; s < CAPACITY; s++)
            shadow_used[s] = 1'b0;

        // hold reset, then release it
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_key_edge_cases();
        test_probe_wraparound();
        test_random_traffic(RANDOM_ITEMS);
        test_table_full();

        // drain outstanding results
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_fifo.sv
sv/lpht_front.sv
sv/lpht_back.sv
sv/linear_probe_hash_table_top.sv
tb/tb_linear_probe_hash_table_top.sv
